/* hdl/lcr_pkg.sv */
// Shared types and constants of the line and circle rasterizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lcr_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int BPP_W      = 3;
  localparam int PIX_W      = 14;
  localparam int ADDR_W     = 26;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LANES      = 4;
  localparam int LANE_IDX_W = 2;
  localparam int PEND_W     = 3;

  // Command codes.
  localparam logic [1:0] CMD_LINE   = 2'd0;
  localparam logic [1:0] CMD_CIRCLE = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  // Configuration reset values.
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH     = 13'd4096;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT    = 13'd4096;
  localparam logic [BPP_W-1:0] RST_BYTES_PER_PIXEL = 3'd3;

  // Active shape.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_LINE   = 3'b010,
    MODE_CIRCLE = 3'b100
  } mode_t;

  // One pixel on its way from the shape engine to the address stage.
  typedef struct packed {
    logic signed [PIX_W-1:0] row;
    logic signed [PIX_W-1:0] col;
    logic [COLOR_W-1:0]      color;
    logic                    last;
    logic                    done;
  } pix_t;

endpackage

`default_nettype wire

/* hdl/lcr_shape.sv */
// Shape engine: holds line and circle state, runs one iteration per step
// transaction and hands out its pixels one a cycle when not stalled. Uses lcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcr_shape (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [1:0]                    cmd,
  input  wire  [lcr_pkg::COORD_W-1:0]   row_a,
  input  wire  [lcr_pkg::COORD_W-1:0]   col_a,
  input  wire  [lcr_pkg::COORD_W-1:0]   row_b,
  input  wire  [lcr_pkg::COORD_W-1:0]   col_b,
  input  wire  [lcr_pkg::COORD_W-1:0]   radius,
  input  wire  [lcr_pkg::COLOR_W-1:0]   color,
  output logic                          pix_valid,
  input  wire                           pix_ready,
  output lcr_pkg::pix_t                 pix,
  output logic [lcr_pkg::PEND_W-1:0]    pend_cnt
);
  import lcr_pkg::*;

  // Shape state.
  mode_t                     mode;
  logic signed [12:0]        line_row;
  logic signed [12:0]        line_col;
  logic [COORD_W-1:0]        line_end_row;
  logic [COORD_W-1:0]        line_end_col;
  logic                      row_dir_neg;
  logic                      col_dir_neg;
  logic signed [12:0]        row_span;
  logic signed [13:0]        col_span_neg;
  logic signed [14:0]        line_error;
  logic [COORD_W-1:0]        center_row;
  logic [COORD_W-1:0]        center_col;
  logic signed [13:0]        circ_x;
  logic signed [13:0]        circ_y;
  logic signed [15:0]        circ_error;

  // Pixel buffer of one step.
  logic signed [PIX_W-1:0]   lane_row [LANES];
  logic signed [PIX_W-1:0]   lane_col [LANES];
  logic [COLOR_W-1:0]        buf_color;
  logic                      buf_done;
  logic [PEND_W-1:0]         cnt, cnt_next;
  logic [LANE_IDX_W-1:0]     idx, idx_next;

  logic pop, accept, step_line, step_circle;

  // Line iteration.
  logic                      line_hit;
  logic signed [16:0]        e2;
  logic                      row_move, col_move;
  logic signed [16:0]        line_err_sum;
  logic [COORD_W-1:0]        rdiff, cdiff;

  // Circle iteration.
  logic signed [17:0]        cx, cy, ce, cy1, ce1, cx1, ce2;
  logic                      c1, c2, circ_fin;
  logic signed [PIX_W-1:0]   cr, cc;

  assign pop         = pix_valid && pix_ready;
  assign in_ready    = (cnt == '0) || ((cnt == PEND_W'(1)) && pix_ready);
  assign accept      = in_valid && in_ready;
  assign step_line   = accept && (cmd == CMD_STEP) && (mode == MODE_LINE);
  assign step_circle = accept && (cmd == CMD_STEP) && (mode == MODE_CIRCLE);

  // Setup of a new line.
  assign rdiff = (row_b > row_a) ? (row_b - row_a) : (row_a - row_b);
  assign cdiff = (col_b > col_a) ? (col_b - col_a) : (col_a - col_b);

  // Error-term line step.
  always_comb begin
    line_hit = (line_row == signed'({1'b0, line_end_row}))
            && (line_col == signed'({1'b0, line_end_col}));
    e2       = 17'(line_error) <<< 1;
    row_move = e2 >= 17'(col_span_neg);
    col_move = e2 <= 17'(row_span);
    line_err_sum = 17'(line_error)
                 + (row_move ? 17'(col_span_neg) : 17'sd0)
                 + (col_move ? 17'(row_span) : 17'sd0);
  end

  // Midpoint circle step.
  always_comb begin
    cx  = 18'(circ_x);
    cy  = 18'(circ_y);
    ce  = 18'(circ_error);
    c1  = ce <= cy;
    cy1 = c1 ? cy + 18'sd1 : cy;
    ce1 = c1 ? ce + (cy1 <<< 1) + 18'sd1 : ce;
    c2  = (ce > cx) || (ce1 > cy1);
    cx1 = c2 ? cx + 18'sd1 : cx;
    ce2 = c2 ? ce1 + (cx1 <<< 1) + 18'sd1 : ce1;
    circ_fin = !cx1[17];
    cr  = signed'({2'b00, center_row});
    cc  = signed'({2'b00, center_col});
  end

  // Buffer occupancy.
  always_comb begin
    cnt_next = cnt;
    idx_next = idx;
    if (pop) begin
      cnt_next = cnt - PEND_W'(1);
      idx_next = idx + LANE_IDX_W'(1);
    end
    if (step_line) begin
      cnt_next = PEND_W'(1);
      idx_next = '0;
    end else if (step_circle) begin
      cnt_next = PEND_W'(LANES);
      idx_next = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cnt  <= '0;
      idx  <= '0;
    end else begin
      cnt <= cnt_next;
      idx <= idx_next;
      if (accept) begin
        case (cmd)
          CMD_LINE:   mode <= MODE_LINE;
          CMD_CIRCLE: mode <= MODE_CIRCLE;
          CMD_STEP: begin
            if (step_line && line_hit) mode <= MODE_IDLE;
            if (step_circle && circ_fin) mode <= MODE_IDLE;
          end
          default:    mode <= mode;
        endcase
      end
    end
  end

  // Shape state and pixel buffer.
  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_LINE)) begin
      line_row     <= signed'({1'b0, row_a});
      line_col     <= signed'({1'b0, col_a});
      line_end_row <= row_b;
      line_end_col <= col_b;
      row_dir_neg  <= !(row_a < row_b);
      col_dir_neg  <= !(col_a < col_b);
      row_span     <= signed'({1'b0, rdiff});
      col_span_neg <= 14'sd0 - signed'({2'b00, cdiff});
      line_error   <= signed'({3'b000, rdiff}) - signed'({3'b000, cdiff});
      buf_color    <= color;
    end
    if (accept && (cmd == CMD_CIRCLE)) begin
      center_row <= row_a;
      center_col <= col_a;
      circ_x     <= 14'sd0 - signed'({2'b00, radius});
      circ_y     <= 14'sd0;
      circ_error <= 16'sd2 - signed'({3'b000, radius, 1'b0});
      buf_color  <= color;
    end
    if (step_line) begin
      lane_row[0] <= 14'(line_row);
      lane_col[0] <= 14'(line_col);
      buf_done    <= line_hit;
      if (!line_hit) begin
        line_error <= line_err_sum[14:0];
        if (row_move) line_row <= row_dir_neg ? line_row - 13'sd1 : line_row + 13'sd1;
        if (col_move) line_col <= col_dir_neg ? line_col - 13'sd1 : line_col + 13'sd1;
      end
    end
    if (step_circle) begin
      lane_row[0] <= cr - circ_x;
      lane_col[0] <= cc + circ_y;
      lane_row[1] <= cr - circ_y;
      lane_col[1] <= cc - circ_x;
      lane_row[2] <= cr + circ_x;
      lane_col[2] <= cc - circ_y;
      lane_row[3] <= cr + circ_y;
      lane_col[3] <= cc + circ_x;
      buf_done    <= circ_fin;
      circ_x      <= cx1[13:0];
      circ_y      <= cy1[13:0];
      circ_error  <= ce2[15:0];
    end
  end

  // Pixel handed to the address stage.
  always_comb begin
    pix_valid = cnt != '0;
    pix.row   = lane_row[idx];
    pix.col   = lane_col[idx];
    pix.color = buf_color;
    pix.last  = cnt == PEND_W'(1);
    pix.done  = buf_done && (cnt == PEND_W'(1));
  end

  assign pend_cnt = cnt;

endmodule

`default_nettype wire

/* hdl/lcr_addr.sv */
// Address stage: bounds check and byte address of each pixel over two
// registered steps, the second being the result register. Uses lcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcr_addr #(
  parameter int MAX_DIM = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                pix_valid,
  output logic                               pix_ready,
  input  wire  lcr_pkg::pix_t                pix,
  input  wire  [lcr_pkg::DIM_W-1:0]          image_width,
  input  wire  [lcr_pkg::DIM_W-1:0]          image_height,
  input  wire  [lcr_pkg::BPP_W-1:0]          bytes_per_pixel,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [lcr_pkg::PIX_W-1:0]   pixel_row,
  output logic signed [lcr_pkg::PIX_W-1:0]   pixel_col,
  output logic [lcr_pkg::ADDR_W-1:0]         pixel_addr,
  output logic                               in_bounds,
  output logic [lcr_pkg::COLOR_W-1:0]        pixel_color,
  output logic                               end_of_step,
  output logic                               shape_done
);
  import lcr_pkg::*;

  localparam int DIM_MAXVAL = (1 << DIM_W) - 1;
  localparam int DIM_CAP    = (MAX_DIM < DIM_MAXVAL) ? MAX_DIM : DIM_MAXVAL;
  localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(DIM_CAP);

  logic [DIM_W-1:0]        w_eff, h_eff;
  logic                    inb;
  logic [ADDR_W-1:0]       lin;
  logic [ADDR_W+BPP_W-1:0] scaled;
  logic                    s1_adv, s2_adv;

  // First step registers.
  logic                    s1_valid;
  pix_t                    s1_pix;
  logic                    s1_inb;
  logic [ADDR_W-1:0]       s1_lin;

  // Image size saturated at the supported dimension.
  assign w_eff = (image_width  > DIM_LIM) ? DIM_LIM : image_width;
  assign h_eff = (image_height > DIM_LIM) ? DIM_LIM : image_height;

  // Bounds and linear pixel index.
  always_comb begin
    inb = !pix.row[PIX_W-1] && !pix.col[PIX_W-1]
       && (pix.row[DIM_W-1:0] < h_eff) && (pix.col[DIM_W-1:0] < w_eff);
    lin = ADDR_W'(pix.row[DIM_W-1:0]) * ADDR_W'(w_eff) + ADDR_W'(pix.col[DIM_W-1:0]);
  end

  assign s2_adv    = !out_valid || out_ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign pix_ready = s1_adv;
  assign scaled    = {{BPP_W{1'b0}}, s1_lin} * {{ADDR_W{1'b0}}, bytes_per_pixel};

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= pix_valid;
      if (s2_adv) out_valid <= s1_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (s1_adv && pix_valid) begin
      s1_pix <= pix;
      s1_inb <= inb;
      s1_lin <= lin;
    end
    if (s2_adv && s1_valid) begin
      pixel_row   <= s1_pix.row;
      pixel_col   <= s1_pix.col;
      pixel_addr  <= s1_inb ? scaled[ADDR_W-1:0] : '0;
      in_bounds   <= s1_inb;
      pixel_color <= s1_pix.color;
      end_of_step <= s1_pix.last;
      shape_done  <= s1_pix.done;
    end
  end

endmodule

`default_nettype wire

/* hdl/line_circle_rasterizer.sv */
// Top level of the line and circle rasterizer: configuration registers,
// shape engine and address stage. Uses lcr_pkg, lcr_shape and lcr_addr.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    cmd, row_a, col_a, row_b, col_b, radius, color
//   output    out_valid / out_ready  pixel_row, pixel_col, pixel_addr, in_bounds,
//                                    pixel_color, end_of_step, shape_done
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A line step fills the pixel buffer with one pixel, a circle step with four, one
// per quadrant; the result port carries one pixel a cycle while not stalled.
// A pixel is held in the pixel buffer, then the first step and the result register.
// Reset clears the shape to idle, empties the pipeline and restores the
// configuration (width 4096, height 4096, three bytes per pixel).
// A stalled output holds the pipeline; the input stalls once the pixel buffer
// cannot be emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module line_circle_rasterizer #(
  parameter int MAX_DIM = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [lcr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [1:0]                          cmd,
  input  wire  [lcr_pkg::COORD_W-1:0]         row_a,
  input  wire  [lcr_pkg::COORD_W-1:0]         col_a,
  input  wire  [lcr_pkg::COORD_W-1:0]         row_b,
  input  wire  [lcr_pkg::COORD_W-1:0]         col_b,
  input  wire  [lcr_pkg::COORD_W-1:0]         radius,
  input  wire  [lcr_pkg::COLOR_W-1:0]         color,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [lcr_pkg::PIX_W-1:0]    pixel_row,
  output logic signed [lcr_pkg::PIX_W-1:0]    pixel_col,
  output logic [lcr_pkg::ADDR_W-1:0]          pixel_addr,
  output logic                                in_bounds,
  output logic [lcr_pkg::COLOR_W-1:0]         pixel_color,
  output logic                                end_of_step,
  output logic                                shape_done
);
  import lcr_pkg::*;

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [BPP_W-1:0]  bytes_per_pixel;

  logic              pix_valid;
  logic              pix_ready;
  pix_t              pix;
  logic [PEND_W-1:0] pend_cnt;

  // Configuration writes; an index beyond the register list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      bytes_per_pixel <= RST_BYTES_PER_PIXEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data;
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default:             image_width     <= image_width;
      endcase
    end
  end

  // Shape engine.
  lcr_shape u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .row_a     (row_a),
    .col_a     (col_a),
    .row_b     (row_b),
    .col_b     (col_b),
    .radius    (radius),
    .color     (color),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .pend_cnt  (pend_cnt)
  );

  // Bounds check and address.
  lcr_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk             (clk),
    .rst             (rst),
    .pix_valid       (pix_valid),
    .pix_ready       (pix_ready),
    .pix             (pix),
    .image_width     (image_width),
    .image_height    (image_height),
    .bytes_per_pixel (bytes_per_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel_row       (pixel_row),
    .pixel_col       (pixel_col),
    .pixel_addr      (pixel_addr),
    .in_bounds       (in_bounds),
    .pixel_color     (pixel_color),
    .end_of_step     (end_of_step),
    .shape_done      (shape_done)
  );

  // The pixel buffer never holds more than one step.
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= PEND_W'(LANES))
    else $error("pixel buffer holds more than four pixels");

  // A new transaction is taken only when the buffer is empty or draining its last pixel.
  a_ready_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (pend_cnt == PEND_W'(0)) || (pend_cnt == PEND_W'(1)))
    else $error("input ready with pixels still pending");

  // The final pixel of a shape always closes its step.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && shape_done) |-> end_of_step)
    else $error("shape done without end of step");

  // Pixels outside the image carry a zero address.
  a_oob_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_bounds) |-> (pixel_addr == '0))
    else $error("out of bounds pixel with nonzero address");

endmodule

`default_nettype wire

/* tb/lcr_pixel_checker.sv */
// Pixel checker for the line and circle rasterizer: watches the configuration, command
// and pixel channels, predicts every pixel and compares it field by field.
// Depends on lcr_pkg for field widths, command codes, register indexes and the mode type.
`timescale 1ns / 1ps

module lcr_pixel_checker #(
  parameter int MAX_DIM = 4096
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire  [lcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [lcr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire                                 in_valid,
  input  wire                                 in_ready,
  input  wire  [1:0]                          cmd,
  input  wire  [lcr_pkg::COORD_W-1:0]         row_a,
  input  wire  [lcr_pkg::COORD_W-1:0]         col_a,
  input  wire  [lcr_pkg::COORD_W-1:0]         row_b,
  input  wire  [lcr_pkg::COORD_W-1:0]         col_b,
  input  wire  [lcr_pkg::COORD_W-1:0]         radius,
  input  wire  [lcr_pkg::COLOR_W-1:0]         color,
  input  wire                                 out_valid,
  input  wire                                 out_ready,
  input  wire  signed [lcr_pkg::PIX_W-1:0]    pixel_row,
  input  wire  signed [lcr_pkg::PIX_W-1:0]    pixel_col,
  input  wire  [lcr_pkg::ADDR_W-1:0]          pixel_addr,
  input  wire                                 in_bounds,
  input  wire  [lcr_pkg::COLOR_W-1:0]         pixel_color,
  input  wire                                 end_of_step,
  input  wire                                 shape_done,
  output int                                  mismatches,
  output int                                  outstanding
);
  import lcr_pkg::*;

  // One predicted pixel, at the widths of the result port.
  typedef struct packed {
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   col;
    logic [ADDR_W-1:0]  addr;
    logic               inb;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               done;
  } pixel_t;

  pixel_t expected_pixels[$];
  int errors = 0;

  // Shadow copy of the configuration registers.
  int img_width  = RST_IMAGE_WIDTH;
  int img_height = RST_IMAGE_HEIGHT;
  int img_bpp    = RST_BYTES_PER_PIXEL;

  // Shadow copy of the shape state.
  mode_t shape = MODE_IDLE;
  int ln_row = 0, ln_col = 0, ln_end_row = 0, ln_end_col = 0;
  int ln_row_step = 0, ln_col_step = 0, ln_drow = 0, ln_dcol_neg = 0, ln_err = 0;
  int ci_row = 0, ci_col = 0, ci_x = 0, ci_y = 0, ci_err = 0;
  logic [COLOR_W-1:0] latched_color = '0;

  assign mismatches = errors;

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("%0t: pixel check: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Builds one pixel: bounds saturate at MAX_DIM, the address wraps at the port width.
  function automatic pixel_t make_pixel(int r, int c, bit last, bit done);
    int w;
    int h;
    longint a;
    pixel_t p;
    w = (img_width > MAX_DIM) ? MAX_DIM : img_width;
    h = (img_height > MAX_DIM) ? MAX_DIM : img_height;
    p.row = r[PIX_W-1:0];
    p.col = c[PIX_W-1:0];
    p.inb = (r >= 0) && (c >= 0) && (r < h) && (c < w);
    a = 0;
    if (p.inb) a = (longint'(r) * w + c) * img_bpp;
    p.addr = a[ADDR_W-1:0];
    p.color = latched_color;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // Advances the shadow state by one command transaction and queues its pixels.
  task automatic apply_command(input logic [1:0] c, input int ra, input int ca,
                               input int rb, input int cb, input int rad,
                               input logic [COLOR_W-1:0] col);
    int e2;
    int px;
    int py;
    int perr;
    bit finished;
    case (c)
      CMD_LINE: begin
        ln_row = ra;
        ln_col = ca;
        ln_end_row = rb;
        ln_end_col = cb;
        ln_row_step = (ra < rb) ? 1 : -1;
        ln_col_step = (ca < cb) ? 1 : -1;
        ln_drow = (rb > ra) ? rb - ra : ra - rb;
        ln_dcol_neg = -((cb > ca) ? cb - ca : ca - cb);
        ln_err = ln_drow + ln_dcol_neg;
        latched_color = col;
        shape = MODE_LINE;
      end
      CMD_CIRCLE: begin
        ci_row = ra;
        ci_col = ca;
        ci_x = -rad;
        ci_y = 0;
        ci_err = 2 - 2 * rad;
        latched_color = col;
        shape = MODE_CIRCLE;
      end
      CMD_STEP: begin
        if (shape == MODE_LINE) begin
          finished = (ln_row == ln_end_row) && (ln_col == ln_end_col);
          expected_pixels.push_back(make_pixel(ln_row, ln_col, 1'b1, finished));
          if (finished) begin
            shape = MODE_IDLE;
          end else begin
            e2 = 2 * ln_err;
            if (e2 >= ln_dcol_neg) begin
              ln_err += ln_dcol_neg;
              ln_row += ln_row_step;
            end
            if (e2 <= ln_drow) begin
              ln_err += ln_drow;
              ln_col += ln_col_step;
            end
          end
        end else if (shape == MODE_CIRCLE) begin
          px = ci_x;
          py = ci_y;
          perr = ci_err;
          if (perr <= ci_y) begin
            ci_y++;
            ci_err += ci_y * 2 + 1;
          end
          if (perr > ci_x || ci_err > ci_y) begin
            ci_x++;
            ci_err += ci_x * 2 + 1;
          end
          finished = (ci_x >= 0);
          // Four quadrant points, the last one closes the step.
          expected_pixels.push_back(make_pixel(ci_row - px, ci_col + py, 1'b0, 1'b0));
          expected_pixels.push_back(make_pixel(ci_row - py, ci_col - px, 1'b0, 1'b0));
          expected_pixels.push_back(make_pixel(ci_row + px, ci_col - py, 1'b0, 1'b0));
          expected_pixels.push_back(make_pixel(ci_row + py, ci_col + px, 1'b1, finished));
          if (finished) shape = MODE_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  // Per-edge bookkeeping: configuration first, then pixel check, then new commands.
  always @(posedge clk) begin : watch
    pixel_t want;
    if (rst) begin
      expected_pixels.delete();
      img_width = RST_IMAGE_WIDTH;
      img_height = RST_IMAGE_HEIGHT;
      img_bpp = RST_BYTES_PER_PIXEL;
      shape = MODE_IDLE;
      ln_row = 0; ln_col = 0; ln_end_row = 0; ln_end_col = 0;
      ln_row_step = 0; ln_col_step = 0; ln_drow = 0; ln_dcol_neg = 0; ln_err = 0;
      ci_row = 0; ci_col = 0; ci_x = 0; ci_y = 0; ci_err = 0;
      latched_color = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:     img_width = cfg_data;
          REG_IMAGE_HEIGHT:    img_height = cfg_data;
          REG_BYTES_PER_PIXEL: img_bpp = cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel (%0d, %0d) with no expectation waiting",
                                    pixel_row, pixel_col));
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_row", $unsigned(pixel_row), want.row);
          check_field("pixel_col", $unsigned(pixel_col), want.col);
          check_field("pixel_addr", pixel_addr, want.addr);
          check_field("in_bounds", in_bounds, want.inb);
          check_field("pixel_color", pixel_color, want.color);
          check_field("end_of_step", end_of_step, want.last);
          check_field("shape_done", shape_done, want.done);
        end
      end
      if (in_valid && in_ready)
        apply_command(cmd, row_a, col_a, row_b, col_b, radius, color);
    end
    outstanding <= expected_pixels.size();
  end

endmodule

/* tb/tb_line_circle_rasterizer.sv */
// Testbench top for the line and circle rasterizer: clock, reset, configuration and
// command stimulus, receiver stalls and the verdict. Uses lcr_pkg and lcr_pixel_checker.
`timescale 1ns / 1ps

module tb_line_circle_rasterizer;
  import lcr_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 310;
  localparam int ITEMS_PER_PHASE = 40;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [1:0]            cmd = '0;
  logic [COORD_W-1:0]    row_a = '0;
  logic [COORD_W-1:0]    col_a = '0;
  logic [COORD_W-1:0]    row_b = '0;
  logic [COORD_W-1:0]    col_b = '0;
  logic [COORD_W-1:0]    radius = '0;
  logic [COLOR_W-1:0]    color = '0;
  logic                  out_ready = 1'b0;

  wire                   cfg_ready;
  wire                   in_ready;
  wire                   out_valid;
  wire signed [PIX_W-1:0] pixel_row;
  wire signed [PIX_W-1:0] pixel_col;
  wire [ADDR_W-1:0]      pixel_addr;
  wire                   in_bounds;
  wire [COLOR_W-1:0]     pixel_color;
  wire                   end_of_step;
  wire                   shape_done;

  int mismatches;
  int outstanding;

  // Sender and receiver pacing state.
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int stall_left = 0;

  // Current image size, used to aim shapes near the image.
  int cur_w = RST_IMAGE_WIDTH;
  int cur_h = RST_IMAGE_HEIGHT;

  line_circle_rasterizer #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .row_a(row_a), .col_a(col_a), .row_b(row_b), .col_b(col_b),
    .radius(radius), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .pixel_addr(pixel_addr),
    .in_bounds(in_bounds), .pixel_color(pixel_color),
    .end_of_step(end_of_step), .shape_done(shape_done)
  );

  lcr_pixel_checker #(.MAX_DIM(MAX_DIM)) chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .row_a(row_a), .col_a(col_a), .row_b(row_b), .col_b(col_b),
    .radius(radius), .color(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .pixel_addr(pixel_addr),
    .in_bounds(in_bounds), .pixel_color(pixel_color),
    .end_of_step(end_of_step), .shape_done(shape_done),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: switches between always ready, coin-flip and mostly stalled stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Sends one command transaction; bursts of random length with random gaps between.
  task automatic send_cmd(input logic [1:0] c, input int ra, input int ca, input int rb,
                          input int cb, input int rad, input logic [COLOR_W-1:0] col);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row_a <= ra[COORD_W-1:0];
    col_a <= ca[COORD_W-1:0];
    row_b <= rb[COORD_W-1:0];
    col_b <= cb[COORD_W-1:0];
    radius <= rad[COORD_W-1:0];
    color <= col;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
  endtask

  // Starts a shape and issues a number of steps with random unused fields.
  task automatic draw_shape(input logic [1:0] c, input int ra, input int ca, input int rb,
                            input int cb, input int rad, input logic [COLOR_W-1:0] col,
                            input int steps);
    send_cmd(c, ra, ca, rb, cb, rad, col);
    repeat (steps)
      send_cmd(CMD_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom);
  endtask

  // Waits until every predicted pixel has come out and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all registers while the block is idle; the unused index must be ignored.
  task automatic configure(input int w, input int h, input int bpp);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BYTES_PER_PIXEL, bpp);
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Half the coordinates anywhere, half near the configured image.
  function automatic int pick_coord(int dim);
    int hi;
    hi = (dim + 3 > 4095) ? 4095 : dim + 3;
    if ($urandom_range(0, 1)) return $urandom_range(0, 4095);
    return $urandom_range(0, hi);
  endfunction

  function automatic int near_coord(int base);
    int v;
    v = base + int'($urandom_range(0, 16)) - 8;
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(4097, 8191);
      1:       return $urandom_range(1, 16);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  initial begin : stimulus
    int phase;
    int cfg_mark;
    int kind;
    int ra, ca, rb, cb, rad, steps, dr, dc;

    phase = 0;
    cfg_mark = -ITEMS_PER_PHASE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset configuration.
    // A step with no active shape and the unused command code give nothing.
    send_cmd(CMD_STEP, 4095, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 4095, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
    // Single-point line, then lines in both directions at the image corners.
    draw_shape(CMD_LINE, 0, 0, 0, 0, 0, 32'h0000_0000, 1);
    draw_shape(CMD_LINE, 0, 0, 3, 5, 4095, $urandom, 6);
    draw_shape(CMD_LINE, 4095, 4095, 4092, 4093, 0, 32'hFFFF_FFFF, 4);
    // Radius zero gives the center four times; a circle on the edge leaves the image.
    draw_shape(CMD_CIRCLE, 0, 0, 4095, 4095, 0, $urandom, 1);
    draw_shape(CMD_CIRCLE, 4095, 0, 0, 4095, 2, 32'hFFFF_FFFF, 5);

    // Random part: mostly complete small shapes, some cut short, some noise.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent - cfg_mark >= ITEMS_PER_PHASE) begin
        case (phase)
          0:       configure(0, 0, 0);
          1:       configure(1, 1, 1);
          2:       configure(8191, 8191, 7);
          3:       configure(4096, 4096, 4);
          default: configure(pick_dim(), pick_dim(), $urandom_range(0, 7));
        endcase
        phase++;
        cfg_mark = items_sent;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        ra = pick_coord(cur_h);
        ca = pick_coord(cur_w);
        rb = near_coord(ra);
        cb = near_coord(ca);
        dr = (rb > ra) ? rb - ra : ra - rb;
        dc = (cb > ca) ? cb - ca : ca - cb;
        steps = ((dr > dc) ? dr : dc) + 1;
        if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
        draw_shape(CMD_LINE, ra, ca, rb, cb, $urandom_range(0, 4095), $urandom, steps);
      end else if (kind < 70) begin
        rad = $urandom_range(0, 6);
        steps = 2 * rad + 1;
        if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps);
        draw_shape(CMD_CIRCLE, pick_coord(cur_h), pick_coord(cur_w),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), rad, $urandom, steps);
      end else if (kind < 85) begin
        // Full-range shapes, usually replaced before they finish.
        draw_shape($urandom_range(0, 1) ? CMD_CIRCLE : CMD_LINE,
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom, $urandom_range(0, 8));
      end else begin
        send_cmd($urandom_range(0, 1) ? CMD_UNUSED : CMD_STEP,
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom);
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
